/* src/plfd_pkg.sv */
// Shared types and constants for the page-layout framebuffer draw unit.
// Depends on nothing; imported by the top level.
`default_nettype none

package plfd_pkg;

	// Field and internal coordinate widths
	localparam int MODE_W  = 2;
	localparam int COORD_W = 9;
	localparam int SCALE_W = 2;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_FILL = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BLIT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_READ,
		ST_RWAIT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* src/plfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module plfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* src/page_layout_framebuffer_draw_unit.sv */
// Top level of the page-layout framebuffer draw unit: sequencer, byte walker and result register.
// Depends on plfd_pkg and plfd_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command: fill a rectangle, draw one
//   bitmap row, or read back one framebuffer byte. Output channel (out_valid / out_stall)
//   returns exactly one read_data byte per command (zero except for reads).
//   The unit takes one command at a time; in_stall stays high until it is done.
//   Drawing walks the touched framebuffer bytes one per cycle with a read-modify-write
//   pass through the single RAM port pair: columns inner, pages outer. A drawing command
//   raises out_valid after setup, the walk, a write-drain state and the result load. A read
//   passes through setup, the RAM read, the read wait and the result load; an empty, fully
//   clipped or unused-mode command goes from setup straight to the result load. The next
//   command can transfer in the cycle after its result is loaded. After reset the unit
//   clears all PANEL_WIDTH * PANEL_PAGES framebuffer bytes (1024 with the defaults),
//   one byte per cycle, with in_stall high.
//   The result sits in an output register; the next command is taken while it waits.
//   A finished command holds there until the output register is free, so a stalled
//   receiver eventually stalls the input side.
`default_nettype none

module page_layout_framebuffer_draw_unit #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_PAGES  = 8,
	parameter int MAX_ROW_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [plfd_pkg::MODE_W-1:0]   mode,
	input  logic [7:0]                    pos_x,
	input  logic [7:0]                    pos_y,
	input  logic [7:0]                    span_w,
	input  logic [7:0]                    span_h,
	input  logic [31:0]                   row_bits,
	input  logic [plfd_pkg::SCALE_W-1:0]  scale,
	input  logic                          color,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    read_data
);

	import plfd_pkg::*;

	localparam int PANEL_HEIGHT = PANEL_PAGES * 8;
	localparam int DEPTH        = PANEL_WIDTH * PANEL_PAGES;
	localparam int AW           = $clog2(DEPTH);
	localparam int BW           = AW + 1;
	localparam int PGW          = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
	localparam int SW           = ((AW > COORD_W) ? AW : COORD_W) + 1;
	localparam int RBW          = MAX_ROW_BITS;

	// Sequencer state
	state_t state_q, state_d;
	logic [AW-1:0] clr_cnt_q;

	// Latched command
	logic [MODE_W-1:0]  mode_q;
	logic [7:0]         pos_x_q, pos_y_q, span_w_q, span_h_q;
	logic [31:0]        row_bits_q;
	logic [SCALE_W-1:0] scale_q;
	logic               color_q;

	// Walker registers
	logic [COORD_W-1:0] x_end_q, y_end_q, col_q;
	logic [PGW-1:0]     page_q, last_page_q;
	logic [AW-1:0]      row_base_q;
	logic [SCALE_W-1:0] dx_q;
	logic [RBW-1:0]     bits_q;
	logic               read_ok_q;
	logic [7:0]         res_q;

	// Write stage
	logic          wr_en_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [7:0]    mask_s1;
	logic [7:0]    rd_data;

	// Output register
	logic       out_valid_q;
	logic [7:0] data_q;

	// Setup arithmetic
	logic               is_fill;
	logic [7:0]         w_clip;
	logic [9:0]         blit_w;
	logic [COORD_W-1:0] x_lo, y_lo, x_sum, y_sum, x_end, y_end, y_end_m1, page_sel;
	logic               empty;
	logic [BW-1:0]      base_prod;

	// Walker combinational
	logic [SW-1:0]      addr_sum;
	logic [AW-1:0]      walk_addr;
	logic [7:0]         page_mask;
	logic               pix_on;
	logic               last_col;
	logic [COORD_W-1:0] col_inc;

	// Control outputs of the sequencer
	logic          accept, load_out, issue;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;

	// Compute clipped extents from the latched command
	always_comb begin
		is_fill  = (mode_q == MODE_FILL);
		w_clip   = (span_w_q > 8'(MAX_ROW_BITS)) ? 8'(MAX_ROW_BITS) : span_w_q;
		blit_w   = 10'(w_clip) * 10'(scale_q);
		x_lo     = COORD_W'(pos_x_q);
		y_lo     = COORD_W'(pos_y_q);
		x_sum    = x_lo + (is_fill ? COORD_W'(span_w_q) : blit_w[COORD_W-1:0]);
		y_sum    = y_lo + (is_fill ? COORD_W'(span_h_q) : COORD_W'(scale_q));
		x_end    = (x_sum > COORD_W'(PANEL_WIDTH)) ? COORD_W'(PANEL_WIDTH) : x_sum;
		y_end    = (y_sum > COORD_W'(PANEL_HEIGHT)) ? COORD_W'(PANEL_HEIGHT) : y_sum;
		y_end_m1 = y_end - COORD_W'(1);
		empty    = (x_lo >= x_end) || (y_lo >= y_end);
		page_sel = (mode_q == MODE_READ) ? y_lo : (y_lo >> 3);
		base_prod = BW'(page_sel[PGW-1:0]) * BW'(PANEL_WIDTH);
	end

	// Byte address, pixel enable and row mask for the current page
	always_comb begin
		addr_sum  = SW'(row_base_q) + SW'(col_q);
		walk_addr = addr_sum[AW-1:0];
		pix_on    = is_fill ? 1'b1 : bits_q[RBW-1];
		col_inc   = col_q + COORD_W'(1);
		last_col  = (col_inc == x_end_q);
		for (int b = 0; b < 8; b++) begin
			page_mask[b] = (((COORD_W'(page_q) << 3) | COORD_W'(b)) >= y_lo) &&
			               (((COORD_W'(page_q) << 3) | COORD_W'(b)) < y_end_q);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				unique case (mode_q)
					MODE_FILL, MODE_BLIT: state_d = empty ? ST_DONE : ST_WALK;
					MODE_READ: begin
						state_d = ((x_lo < COORD_W'(PANEL_WIDTH)) &&
						           (pos_y_q < 8'(PANEL_PAGES))) ? ST_READ : ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_WALK: begin
				if (last_col && (page_q == last_page_q)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_READ:  state_d = ST_RWAIT;
			ST_RWAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		accept    = (state_q == ST_IDLE) && in_valid;
		load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		issue     = (state_q == ST_WALK) && pix_on;
		ram_we    = wr_en_s1;
		ram_waddr = wr_addr_s1;
		ram_wdata = color_q ? (rd_data | mask_s1) : (rd_data & ~mask_s1);
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end
	end

	plfd_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (walk_addr),
		.rd_data (rd_data)
	);

	// Control registers: state, clear counter, write stage, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			wr_en_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wr_en_s1 <= issue;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Latch the command on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= mode;
			pos_x_q    <= pos_x;
			pos_y_q    <= pos_y;
			span_w_q   <= span_w;
			span_h_q   <= span_h;
			row_bits_q <= row_bits;
			scale_q    <= scale;
			color_q    <= color;
		end
	end

	// Walker setup and column/page stepping, plus write stage, read result and output data
	always_ff @(posedge clk) begin
		wr_addr_s1 <= walk_addr;
		mask_s1    <= page_mask;
		if (state_q == ST_SETUP) begin
			x_end_q     <= x_end;
			y_end_q     <= y_end;
			last_page_q <= y_end_m1[PGW+2:3];
			col_q       <= x_lo;
			page_q      <= page_sel[PGW-1:0];
			row_base_q  <= base_prod[AW-1:0];
			dx_q        <= '0;
			bits_q      <= RBW'(row_bits_q);
			res_q       <= '0;
		end else if (state_q == ST_WALK) begin
			if (last_col) begin
				col_q      <= x_lo;
				page_q     <= page_q + PGW'(1);
				row_base_q <= row_base_q + AW'(PANEL_WIDTH);
				dx_q       <= '0;
				bits_q     <= RBW'(row_bits_q);
			end else begin
				col_q <= col_inc;
				if (dx_q == scale_q - SCALE_W'(1)) begin
					dx_q   <= '0;
					bits_q <= bits_q << 1;
				end else begin
					dx_q <= dx_q + SCALE_W'(1);
				end
			end
		end else if (state_q == ST_RWAIT) begin
			res_q <= rd_data;
		end
		if (load_out) begin
			data_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = data_q;

	// read_ok_q tracks whether a read was issued, for checking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_ok_q <= 1'b0;
		end else if (state_q == ST_SETUP) begin
			read_ok_q <= 1'b0;
		end else if (state_q == ST_READ) begin
			read_ok_q <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en_s1)
		else $error("framebuffer write pending while idle");

	a_walk_on_panel: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (col_q < COORD_W'(PANEL_WIDTH)))
		else $error("walker issued a column off the panel");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s1 |-> (BW'(wr_addr_s1) < BW'(DEPTH)))
		else $error("framebuffer write address out of range");

	a_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !read_ok_q) |=> (read_data == 8'd0))
		else $error("nonzero result for a command without a read");
`endif

endmodule

`default_nettype wire
